@@ src/gwa_pkg.sv @@
`default_nettype none

package gwa_pkg;

   localparam int MAX_MATERIALS_DEF = 32;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int DATA_W     = 32;
   localparam int SUM_W      = 64;
   localparam int FRAC_W     = 16;
   localparam int PROD_W     = SUM_W - FRAC_W;
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 6;
   localparam int MATERIAL_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   // One cell on its way from the front end to the accumulator; counted marks a qualified one
   typedef struct packed {
      logic signed [PROD_W-1:0] product;
      logic signed [DATA_W-1:0] weight;
      logic [INDEX_W-1:0]       index;
      logic                     counted;
      logic                     final_cell;
   } gwa_item_type;

   typedef struct packed {
      logic         valid;
      gwa_item_type entry;
   } gwa_head_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ACC,
      B_EM_START,
      B_EM_LOAD,
      B_EM_DIV
   } gwa_back_state_type;

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIN,
      D_DONE
   } gwa_div_state_type;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W-1:0] s;
      s = a + b;
      if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
         s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

`default_nettype wire

@@ src/gwa_if.sv @@
`default_nettype none

interface gwa_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gwa_pkg::DATA_W-1:0]    weight;
   logic signed [gwa_pkg::DATA_W-1:0]    sample;
   logic [gwa_pkg::MATERIAL_W-1:0]       material;
   logic                                 selected;
   logic                                 in_subset;
   logic                                 final_cell;

   modport source (output valid, weight, sample, material, selected, in_subset, final_cell,
                   input ready);
   modport sink (input valid, weight, sample, material, selected, in_subset, final_cell,
                 output ready);
endinterface

interface gwa_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [gwa_pkg::INDEX_W-1:0]          group_index;
   logic signed [gwa_pkg::DATA_W-1:0]    average;
   logic                                 is_total;
   logic signed [gwa_pkg::SUM_W-1:0]     total_weighted_sum;
   logic signed [gwa_pkg::SUM_W-1:0]     total_weight;
   logic                                 last_result;

   modport source (output valid, group_index, average, is_total, total_weighted_sum,
                   total_weight, last_result, input ready);
   modport sink (input valid, group_index, average, is_total, total_weighted_sum,
                 total_weight, last_result, output ready);
endinterface

interface gwa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [gwa_pkg::COUNT_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/gwa_div.sv @@
`default_nettype none

module gwa_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [gwa_pkg::SUM_W-1:0] num,
   input  logic signed [gwa_pkg::SUM_W-1:0] den,
   output logic                             done,
   output logic signed [gwa_pkg::DATA_W-1:0] quot
);
   import gwa_pkg::*;

   localparam int STEP_W = $clog2(DATA_W);

   gwa_div_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  den_ff, den_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic [DATA_W-1:0] q_ff, q_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              ovf_ff, ovf_in;
   logic signed [DATA_W-1:0] quot_ff, quot_in;

   logic [SUM_W-1:0] mag_num, mag_den;
   logic [SUM_W:0]   trial, diff;
   logic             fits;

   assign mag_num = num[SUM_W-1] ? (~num + 1'b1) : num;
   assign mag_den = den[SUM_W-1] ? (~den + 1'b1) : den;
   assign trial   = {rem_ff, low_ff[DATA_W-1]};
   assign diff    = trial - {1'b0, den_ff};
   assign fits    = trial >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      ovf_in   = ovf_ff;
      quot_in  = quot_ff;
      if (start) begin
         rem_in   = {{FRAC_W{1'b0}}, mag_num[SUM_W-1:FRAC_W]};
         low_in   = {mag_num[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
         den_in   = mag_den;
         q_in     = '0;
         step_in  = '0;
         neg_in   = num[SUM_W-1] ^ den[SUM_W-1];
         zero_in  = (den == '0);
         // quotient would reach 2^32: the integer part alone already exceeds the range
         ovf_in   = {{FRAC_W{1'b0}}, mag_num[SUM_W-1:FRAC_W]} >= mag_den;
         state_in = ((den == '0) || ovf_in) ? D_FIN : D_RUN;
      end else begin
         unique case (state_ff)
            D_IDLE: state_in = D_IDLE;
            D_RUN: begin
               rem_in  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
               q_in    = {q_ff[DATA_W-2:0], fits};
               low_in  = {low_ff[DATA_W-2:0], 1'b0};
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_W'(DATA_W - 1)) begin
                  state_in = D_FIN;
               end
            end
            D_FIN: begin
               if (zero_ff) begin
                  quot_in = '0;
               end else if (ovf_ff || q_ff[DATA_W-1]) begin
                  quot_in = neg_ff ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
               end else begin
                  quot_in = neg_ff ? (~q_ff + 1'b1) : q_ff;
               end
               state_in = D_DONE;
            end
            D_DONE: state_in = D_DONE;
            default: state_in = D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      quot_ff <= quot_in;
   end

   assign done = (state_ff == D_DONE);
   assign quot = quot_ff;

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_DONE && zero_ff) |-> (quot_ff == '0))
      else $error("division by a zero weight sum gave a nonzero average");

endmodule

`default_nettype wire

@@ src/gwa_front.sv @@
`default_nettype none

module gwa_front #(
   parameter int MAX_MATERIALS = gwa_pkg::MAX_MATERIALS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gwa_req_if.sink               req,
   output logic                  push_valid,
   output gwa_pkg::gwa_item_type push_item,
   input  logic                  push_ready
);
   import gwa_pkg::*;

   logic         stage_valid_ff, stage_valid_in;
   gwa_item_type stage_ff, stage_in;
   logic         accept;
   logic         counted;
   logic signed [SUM_W-1:0]    full_product;
   logic [MATERIAL_W-1:0]      material_less;

   assign req.ready     = !stage_valid_ff || push_ready;
   assign accept        = req.valid && req.ready;
   assign counted       = req.selected && req.in_subset && (req.material != '0) &&
                          (req.material <= MATERIAL_W'(MAX_MATERIALS));
   assign full_product  = req.weight * req.sample;
   assign material_less = req.material - 1'b1;

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         // arithmetic shift of the Q32.32 product: rounds toward minus infinity
         stage_in.product    = full_product[SUM_W-1:FRAC_W];
         stage_in.weight     = req.weight;
         stage_in.index      = material_less[INDEX_W-1:0];
         stage_in.counted    = counted;
         stage_in.final_cell = req.final_cell;
      end
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_item  = stage_ff;

endmodule

`default_nettype wire

@@ src/gwa_queue.sv @@
`default_nettype none

module gwa_queue #(
   parameter int DEPTH = gwa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  gwa_pkg::gwa_item_type push_item,
   output logic                  push_ready,
   input  logic                  pop,
   output gwa_pkg::gwa_head_type head
);
   import gwa_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gwa_item_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      !head.valid |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty but pointers disagree");

endmodule

`default_nettype wire

@@ src/gwa_back.sv @@
`default_nettype none

module gwa_back #(
   parameter int MAX_MATERIALS = gwa_pkg::MAX_MATERIALS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  gwa_pkg::gwa_head_type       head,
   output logic                        pop,
   input  logic [gwa_pkg::COUNT_W-1:0] material_count,
   gwa_rsp_if.source                   rsp
);
   import gwa_pkg::*;

   localparam int ADDR_W = (MAX_MATERIALS > 1) ? $clog2(MAX_MATERIALS) : 1;

   gwa_back_state_type state_ff, state_in;

   logic signed [SUM_W-1:0] wsum_mem [MAX_MATERIALS];
   logic signed [SUM_W-1:0] wgt_mem  [MAX_MATERIALS];
   logic [MAX_MATERIALS-1:0] valid_ff, valid_in;

   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic signed [SUM_W-1:0] rd_wsum_ff, rd_wgt_ff;
   logic                    rd_hit_ff;
   logic signed [SUM_W-1:0] eff_wsum, eff_wgt;

   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic signed [SUM_W-1:0] prod_ext, wgt_ext;
   logic signed [SUM_W-1:0] new_wsum, new_wgt;

   gwa_item_type            cur_ff, cur_in;
   logic signed [SUM_W-1:0] tot_wsum_ff, tot_wsum_in;
   logic signed [SUM_W-1:0] tot_wgt_ff, tot_wgt_in;
   logic [INDEX_W-1:0]      j_ff, j_in;
   logic [COUNT_W-1:0]      n_ff, n_in;
   logic                    last_group;
   logic                    em_begin;
   logic                    clear_all;

   logic                    div_start, div_done;
   logic signed [SUM_W-1:0] div_num, div_den;
   logic signed [DATA_W-1:0] div_quot;

   logic                    out_load;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]      out_index_ff;
   logic signed [DATA_W-1:0] out_avg_ff;
   logic                    out_total_ff;
   logic signed [SUM_W-1:0] out_twsum_ff, out_twgt_ff;

   // an entry never written since the last clear reads as zero
   assign eff_wsum   = rd_hit_ff ? rd_wsum_ff : '0;
   assign eff_wgt    = rd_hit_ff ? rd_wgt_ff : '0;
   assign wr_addr    = cur_ff.index[ADDR_W-1:0];
   assign prod_ext   = {{(SUM_W-PROD_W){cur_ff.product[PROD_W-1]}}, cur_ff.product};
   assign wgt_ext    = {{(SUM_W-DATA_W){cur_ff.weight[DATA_W-1]}}, cur_ff.weight};
   assign new_wsum   = sat_add(eff_wsum, prod_ext);
   assign new_wgt    = sat_add(eff_wgt, wgt_ext);
   assign last_group = (j_ff == n_ff);
   assign div_num    = last_group ? tot_wsum_ff : eff_wsum;
   assign div_den    = last_group ? tot_wgt_ff : eff_wgt;

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head.entry.index[ADDR_W-1:0];
      wr_en     = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      clear_all = 1'b0;
      em_begin  = 1'b0;
      cur_in    = cur_ff;
      j_in      = j_ff;
      n_in      = n_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               pop    = 1'b1;
               cur_in = head.entry;
               rd_en  = head.entry.counted;
               if (head.entry.counted) begin
                  state_in = B_ACC;
               end else if (head.entry.final_cell) begin
                  em_begin = 1'b1;
                  state_in = B_EM_START;
               end
            end
         end
         B_ACC: begin
            wr_en = 1'b1;
            if (cur_ff.final_cell) begin
               em_begin = 1'b1;
               state_in = B_EM_START;
            end else begin
               state_in = B_IDLE;
            end
         end
         B_EM_START: begin
            rd_en    = !last_group;
            rd_addr  = j_ff[ADDR_W-1:0];
            state_in = B_EM_LOAD;
         end
         B_EM_LOAD: begin
            div_start = 1'b1;
            state_in  = B_EM_DIV;
         end
         B_EM_DIV: begin
            if (div_done && (!rsp_valid_ff || rsp.ready)) begin
               out_load = 1'b1;
               if (last_group) begin
                  clear_all = 1'b1;
                  state_in  = B_IDLE;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = B_EM_START;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      if (em_begin) begin
         j_in = '0;
         n_in = (material_count > COUNT_W'(MAX_MATERIALS)) ? COUNT_W'(MAX_MATERIALS)
                                                            : material_count;
      end
   end

   always_comb begin
      valid_in    = valid_ff;
      tot_wsum_in = tot_wsum_ff;
      tot_wgt_in  = tot_wgt_ff;
      if (clear_all) begin
         valid_in    = '0;
         tot_wsum_in = '0;
         tot_wgt_in  = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
         tot_wsum_in       = sat_add(tot_wsum_ff, prod_ext);
         tot_wgt_in        = sat_add(tot_wgt_ff, wgt_ext);
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         tot_wsum_ff  <= '0;
         tot_wgt_ff   <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         tot_wsum_ff  <= tot_wsum_in;
         tot_wgt_ff   <= tot_wgt_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wsum_mem[wr_addr] <= new_wsum;
         wgt_mem[wr_addr]  <= new_wgt;
      end
      if (rd_en) begin
         rd_wsum_ff <= wsum_mem[rd_addr];
         rd_wgt_ff  <= wgt_mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (out_load) begin
         out_index_ff <= j_ff;
         out_avg_ff   <= div_quot;
         out_total_ff <= last_group;
         out_twsum_ff <= tot_wsum_ff;
         out_twgt_ff  <= tot_wgt_ff;
      end
   end

   gwa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.group_index        = out_index_ff;
   assign rsp.average            = out_avg_ff;
   assign rsp.is_total           = out_total_ff;
   assign rsp.total_weighted_sum = out_twsum_ff;
   assign rsp.total_weight       = out_twgt_ff;
   assign rsp.last_result        = out_total_ff;

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_group) |=> (tot_wsum_ff == '0 && tot_wgt_ff == '0 && valid_ff == '0))
      else $error("bins not cleared after the total result");

   a_group_range: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.is_total) |-> (rsp.group_index < n_ff))
      else $error("group result beyond the reported material count");

   a_write_counted: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cur_ff.counted && $past(rd_en)))
      else $error("bin written without a counted cell and a prior read");

endmodule

`default_nettype wire

@@ src/grouped_weighted_average.sv @@
// Grouped weighted average over a stream of cells.
// req_chan carries one cell per transaction: weight, sample, material,
// selected, in_subset and final_cell. A cell with both flags set and a
// material of 1..MAX_MATERIALS adds W*F and W to its material bin and to
// the run totals. csr_chan writes material_count (always ready); write it
// only while the block is idle.
// The front end takes a cell every cycle while its queue has room; the
// accumulator drains one uncounted cell per cycle, and a counted cell
// through a bin memory read, then a saturating write-back.
// After the final cell, rsp_chan delivers one result per reported material
// and then the total (is_total and last_result set). Each result passes
// through the shared radix-2 divider (32 quotient steps); a zero or
// overflowing weight sum skips the quotient steps.
// The bins are cleared at once after the total is loaded: per-entry valid
// bits drop, so no sweep is needed. Reset does the same and sets
// material_count to 1.
// A stalled rsp_chan holds its result; the divider, queue and finally
// req_chan.ready back up behind it.
`default_nettype none

module grouped_weighted_average #(
   parameter int MAX_MATERIALS = gwa_pkg::MAX_MATERIALS_DEF,
   parameter int QUEUE_DEPTH   = gwa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gwa_req_if.sink    req_chan,
   gwa_rsp_if.source  rsp_chan,
   gwa_csr_if.sink    csr_chan
);
   import gwa_pkg::*;

   logic [COUNT_W-1:0] material_count_ff, material_count_in;
   logic               push_valid, push_ready, pop;
   gwa_item_type       push_item;
   gwa_head_type       head;

   assign csr_chan.ready    = 1'b1;
   assign material_count_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data
                                                                 : material_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         material_count_ff <= COUNT_RESET;
      end else begin
         material_count_ff <= material_count_in;
      end
   end

   gwa_front #(
      .MAX_MATERIALS (MAX_MATERIALS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   gwa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .head       (head)
   );

   gwa_back #(
      .MAX_MATERIALS (MAX_MATERIALS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .material_count (material_count_ff),
      .rsp            (rsp_chan)
   );

endmodule

`default_nettype wire

@@ sim/tb_grouped_weighted_average.sv @@
`default_nettype none

module tb_grouped_weighted_average;
   import gwa_pkg::*;

   localparam int MATERIALS = MAX_MATERIALS_DEF;
   localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] ONE      = 32'sh0001_0000;
   localparam int TOTAL_ITEMS     = 200;
   localparam int PRESSURE_CYCLES = 300;
   localparam int PRESSURE_CELLS  = 24;

   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic signed [DATA_W-1:0] sample;
      logic [MATERIAL_W-1:0]    material;
      logic                     selected;
      logic                     in_subset;
      logic                     final_cell;
   } cell_rec;

   typedef struct packed {
      logic [INDEX_W-1:0]       group_index;
      logic signed [DATA_W-1:0] average;
      logic                     is_total;
      logic signed [SUM_W-1:0]  total_weighted_sum;
      logic signed [SUM_W-1:0]  total_weight;
      logic                     last_result;
   } average_rec;

   class material_average_board;
      logic [COUNT_W-1:0]      material_count;
      logic signed [SUM_W-1:0] bin_weighted [MATERIALS];
      logic signed [SUM_W-1:0] bin_weight [MATERIALS];
      logic signed [SUM_W-1:0] run_weighted;
      logic signed [SUM_W-1:0] run_weight;
      average_rec              expected_averages[$];
      int                      failures;

      function new();
         material_count = COUNT_RESET;
         failures = 0;
         clear_bins();
      endfunction

      function void clear_bins();
         for (int i = 0; i < MATERIALS; i++) begin
            bin_weighted[i] = '0;
            bin_weight[i] = '0;
         end
         run_weighted = '0;
         run_weight = '0;
      endfunction

      function logic signed [SUM_W-1:0] sum_clamped(input logic signed [SUM_W-1:0] a,
                                                   input logic signed [SUM_W-1:0] b);
         logic signed [SUM_W:0] s;
         s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
         if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
         end
         return s[SUM_W-1:0];
      endfunction

      // (num * 2^16) / den, truncated toward zero, clamped to 32 bits
      function logic signed [DATA_W-1:0] bin_average(input logic signed [SUM_W-1:0] num,
                                                     input logic signed [SUM_W-1:0] den);
         logic [SUM_W-1:0]        num_mag;
         logic [SUM_W-1:0]        den_mag;
         logic [SUM_W+FRAC_W-1:0] quotient;
         logic                    negative;
         if (den == 0) begin
            return '0;
         end
         negative = num[SUM_W-1] ^ den[SUM_W-1];
         num_mag = num[SUM_W-1] ? -num : num;
         den_mag = den[SUM_W-1] ? -den : den;
         quotient = {num_mag, {FRAC_W{1'b0}}} / {{FRAC_W{1'b0}}, den_mag};
         if (negative) begin
            return (quotient >= 80'h8000_0000) ? DATA_MIN : -quotient[DATA_W-1:0];
         end
         return (quotient > 80'h7FFF_FFFF) ? DATA_MAX : quotient[DATA_W-1:0];
      endfunction

      function void take_cell(input cell_rec c);
         logic signed [SUM_W-1:0] w_ext;
         logic signed [SUM_W-1:0] f_ext;
         logic signed [SUM_W-1:0] scaled;
         int unsigned             slot;
         int unsigned             reported;
         average_rec              r;
         if (c.selected && c.in_subset && c.material >= 1 && c.material <= MATERIALS) begin
            slot = c.material - 1;
            w_ext = $signed(c.weight);
            f_ext = $signed(c.sample);
            // arithmetic shift rounds the Q32.32 product toward minus infinity
            scaled = (w_ext * f_ext) >>> FRAC_W;
            bin_weighted[slot] = sum_clamped(bin_weighted[slot], scaled);
            bin_weight[slot] = sum_clamped(bin_weight[slot], w_ext);
            run_weighted = sum_clamped(run_weighted, scaled);
            run_weight = sum_clamped(run_weight, w_ext);
         end
         if (!c.final_cell) begin
            return;
         end
         reported = (material_count > MATERIALS) ? MATERIALS : material_count;
         r.total_weighted_sum = run_weighted;
         r.total_weight = run_weight;
         r.is_total = 1'b0;
         r.last_result = 1'b0;
         for (int j = 0; j < reported; j++) begin
            r.group_index = INDEX_W'(j);
            r.average = bin_average(bin_weighted[j], bin_weight[j]);
            expected_averages.push_back(r);
         end
         r.group_index = INDEX_W'(reported);
         r.average = bin_average(run_weighted, run_weight);
         r.is_total = 1'b1;
         r.last_result = 1'b1;
         expected_averages.push_back(r);
         clear_bins();
      endfunction

      function void check_result(input average_rec got);
         average_rec want;
         if (expected_averages.size() == 0) begin
            $error("unexpected result transaction, group_index %0d", got.group_index);
            failures++;
            return;
         end
         want = expected_averages.pop_front();
         if (got.group_index !== want.group_index) begin
            $error("group_index: expected %0d, got %0d", want.group_index, got.group_index);
            failures++;
         end
         if (got.average !== want.average) begin
            $error("average: expected %0d, got %0d", want.average, got.average);
            failures++;
         end
         if (got.is_total !== want.is_total) begin
            $error("is_total: expected %0d, got %0d", want.is_total, got.is_total);
            failures++;
         end
         if (got.total_weighted_sum !== want.total_weighted_sum) begin
            $error("total_weighted_sum: expected %0d, got %0d",
                   want.total_weighted_sum, got.total_weighted_sum);
            failures++;
         end
         if (got.total_weight !== want.total_weight) begin
            $error("total_weight: expected %0d, got %0d", want.total_weight, got.total_weight);
            failures++;
         end
         if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
            failures++;
         end
      endfunction

      function int pending();
         return expected_averages.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   no_idle = 1'b0;
   bit   rsp_open = 1'b0;
   bit   hold_rsp = 1'b0;
   bit   pressure_req = 1'b0;
   int   sent_items = 0;
   material_average_board board;

   gwa_req_if req_bus();
   gwa_rsp_if rsp_bus();
   gwa_csr_if csr_bus();

   assign rsp_bus.ready = rsp_open && !hold_rsp;

   grouped_weighted_average uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_grouped_weighted_average: FAIL");
      $finish;
   end

   function automatic cell_rec build_cell(input logic signed [DATA_W-1:0] w,
                                          input logic signed [DATA_W-1:0] f,
                                          input logic [MATERIAL_W-1:0] mat,
                                          input logic sel, input logic sub, input logic fin);
      cell_rec c;
      c.weight = w;
      c.sample = f;
      c.material = mat;
      c.selected = sel;
      c.in_subset = sub;
      c.final_cell = fin;
      return c;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_q16();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return ONE;
         2: return $urandom_range(0, 32'h0004_0000);
         3: return -$signed(DATA_W'($urandom_range(1, 32'h0004_0000)));
         4: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic cell_rec random_cell(input logic [COUNT_W-1:0] count, input logic fin);
      cell_rec     c;
      int unsigned hi;
      int unsigned pick;
      hi = (count > MATERIALS) ? MATERIALS : count;
      pick = $urandom_range(0, 9);
      c = build_cell(random_q16(), random_q16(), 8'd1, 1'b1, 1'b1, fin);
      if (pick == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            c.material = '0;
         end else begin
            c.material = MATERIAL_W'($urandom_range(MATERIALS + 1, 255));
         end
      end else if (pick == 1) begin
         c.material = MATERIAL_W'($urandom_range(1, MATERIALS));
         c.selected = 1'($urandom_range(0, 1));
         c.in_subset = ~c.selected | 1'($urandom_range(0, 1));
         if (c.selected && c.in_subset) begin
            c.selected = 1'b0;
         end
      end else if (hi > 0 && pick < 7) begin
         c.material = MATERIAL_W'($urandom_range(1, hi));
      end else begin
         c.material = MATERIAL_W'($urandom_range(1, MATERIALS));
      end
      return c;
   endfunction

   task automatic send_cell(input cell_rec c);
      int   gap;
      logic taken;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.weight <= c.weight;
      req_bus.sample <= c.sample;
      req_bus.material <= c.material;
      req_bus.selected <= c.selected;
      req_bus.in_subset <= c.in_subset;
      req_bus.final_cell <= c.final_cell;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
         if (taken) begin
            board.take_cell(c);
            sent_items++;
         end
         @(negedge clock);
      end
   endtask

   task automatic write_material_count(input logic [COUNT_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      board.material_count = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // hold off until every result is out and the accumulator has drained
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // stall the output long enough that the input side backs up
   initial begin
      wait (pressure_req);
      @(negedge clock);
      hold_rsp = 1'b1;
      repeat (PRESSURE_CYCLES) @(negedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      int          gap;
      average_rec  got;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_open <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_open <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
         got.group_index = rsp_bus.group_index;
         got.average = rsp_bus.average;
         got.is_total = rsp_bus.is_total;
         got.total_weighted_sum = rsp_bus.total_weighted_sum;
         got.total_weight = rsp_bus.total_weight;
         got.last_result = rsp_bus.last_result;
         board.check_result(got);
      end
   end

   initial begin
      int unsigned        seq_len;
      int unsigned        pick;
      logic [COUNT_W-1:0] count;
      cell_rec            c;
      board = new();
      req_bus.valid = 1'b0;
      req_bus.weight = '0;
      req_bus.sample = '0;
      req_bus.material = '0;
      req_bus.selected = 1'b0;
      req_bus.in_subset = 1'b0;
      req_bus.final_cell = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // material count still at its reset value; out-of-range and unqualified cells
      send_cell(build_cell(ONE, 32'sh0002_8000, 8'd1, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(32'sh0000_8000, -32'sh0003_0000, 8'd1, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(ONE, ONE, 8'd0, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(ONE, ONE, 8'd33, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(ONE, ONE, 8'd255, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(ONE, ONE, 8'd1, 1'b0, 1'b1, 1'b0));
      send_cell(build_cell(ONE, ONE, 8'd1, 1'b1, 1'b0, 1'b1));

      // field extremes, clamped averages, zero weight sum, negative rounding
      settle_block();
      write_material_count(COUNT_W'(MATERIALS));
      send_cell(build_cell(DATA_MAX, DATA_MAX, 8'd32, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(DATA_MIN, DATA_MIN, 8'd32, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(32'sd1, DATA_MAX, 8'd2, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(32'sd1, DATA_MIN, 8'd3, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(ONE, 32'sh0001_8000, 8'd4, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(-ONE, 32'sd7, 8'd4, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(32'sd3, -32'sh0001_0001, 8'd5, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(DATA_MIN, DATA_MAX, 8'd6, 1'b1, 1'b1, 1'b1));

      // total only
      settle_block();
      write_material_count('0);
      send_cell(build_cell(32'sh0002_0000, 32'sh0003_0000, 8'd1, 1'b1, 1'b1, 1'b1));

      // count above the material limit is clamped
      settle_block();
      write_material_count('1);
      send_cell(build_cell(ONE, -32'sd5, 8'd7, 1'b1, 1'b1, 1'b0));
      send_cell(build_cell(32'sh0000_7FFF, 32'sh0001_2345, 8'd31, 1'b1, 1'b1, 1'b1));

      // keep offering cells back to back while the output is held off
      settle_block();
      count = COUNT_W'(4);
      write_material_count(count);
      pressure_req = 1'b1;
      repeat (2) @(negedge clock);
      no_idle = 1'b1;
      for (int k = 0; k < PRESSURE_CELLS; k++) begin
         send_cell(random_cell(count, (k == 7) || (k == PRESSURE_CELLS - 1)));
      end
      no_idle = 1'b0;

      while (sent_items < TOTAL_ITEMS) begin
         settle_block();
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            count = '0;
         end else if (pick == 1) begin
            count = COUNT_W'(MATERIALS);
         end else if (pick == 2) begin
            count = COUNT_W'($urandom_range(MATERIALS + 1, 63));
         end else begin
            count = COUNT_W'($urandom_range(1, 8));
         end
         write_material_count(count);
         repeat ($urandom_range(1, 3)) begin
            seq_len = $urandom_range(1, 10);
            no_idle = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < seq_len; k++) begin
               c = random_cell(count, k == seq_len - 1);
               // break a run short now and then
               if ($urandom_range(0, 15) == 0) begin
                  c.final_cell = 1'b1;
               end
               send_cell(c);
            end
         end
      end
      no_idle = 1'b0;

      settle_block();
      if (board.failures == 0 && board.pending() == 0) begin
         $display("tb_grouped_weighted_average: PASS");
      end else begin
         $display("tb_grouped_weighted_average: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
src/gwa_pkg.sv
src/gwa_if.sv
src/gwa_div.sv
src/gwa_front.sv
src/gwa_queue.sv
src/gwa_back.sv
src/grouped_weighted_average.sv
sim/tb_grouped_weighted_average.sv
